// ===== rtl/rrss_pkg.sv =====
// Package for the round-robin slice scheduler: sizes, codes and state encoding.
// No dependencies.
package rrss_pkg;
   localparam int MaxTasks = 16;
   localparam int SlotW = $clog2(MaxTasks);
   localparam int CountW = SlotW + 1;
   localparam logic [23:0] TimeMax = 24'hFFFFFF;
   localparam logic [15:0] QuantumReset = 16'd4;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_STEP  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_SLICE  = 2'd0,
      ST_LOADED = 2'd1,
      ST_FULL   = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN1,
      S_ADMIT1,
      S_JUMP,
      S_SCAN2,
      S_ADMIT2,
      S_POP,
      S_RUN,
      S_SCAN3,
      S_ADMIT3,
      S_PUSH,
      S_OUT
   } state_type;
endpackage

// ===== rtl/round_robin_slice_scheduler_top.sv =====
// Top level of the round-robin slice scheduler.
// Depends on rrss_pkg.
//
// channel | dir | fields (tdata low bit up)                         | tuser
// req     | in  | task_id[7:0] arrival_time[23:8] burst_length[39:24] | func[1:0]
// rsp     | out | slice_start[23:0] slice_task[31:24] slice_length[47:32]
//         |     | task_finished[48] first_run[49]                    | status[1:0]
// csr     | in  | time_quantum[15:0]                                 | -
//
// Load and clear: the input beat moves the FSM to S_OUT, which raises the result valid.
// Step: each admission phase scans the table once per admitted task plus a last scan that
// admits none; a scan steps through every loaded entry and then enters its admit state.
// The scan compare is the shared unit.
// req_tready is low while an item is in work or a result waits on rsp.
// Reset empties the table, both queues and time; time_quantum returns to 4.
module round_robin_slice_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // task_id, arrival_time, burst_length
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // slice_start, slice_task, slice_length, finished, first
   output logic [1:0]  rsp_tuser,  // status
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   localparam int SW = rrss_pkg::SlotW;
   localparam int CW = rrss_pkg::CountW;

   rrss_pkg::state_type state_ff, state_in;

   logic [15:0] quantum_ff;
   logic [7:0]  ids_ff [rrss_pkg::MaxTasks];
   logic [15:0] arr_ff [rrss_pkg::MaxTasks];
   logic [15:0] rem_ff [rrss_pkg::MaxTasks];
   logic [rrss_pkg::MaxTasks-1:0] adm_ff, started_ff;
   logic [CW-1:0] loaded_ff;
   logic [SW-1:0] nq_ff [rrss_pkg::MaxTasks];
   logic [SW-1:0] pq_ff [rrss_pkg::MaxTasks];
   logic [SW-1:0] nq_head_ff, pq_head_ff;
   logic [CW-1:0] nq_cnt_ff, pq_cnt_ff;
   logic [23:0]   time_ff;
   logic [CW-1:0] scan_ff;
   logic          best_vld_ff;
   logic [SW-1:0] best_ff;
   logic [SW-1:0] cur_ff;
   logic          rsp_vld_ff;
   logic [55:0]   rsp_data_ff;
   logic [1:0]    rsp_user_ff;

   logic          scan_done;
   logic [SW-1:0] scan_idx;
   logic          better;
   logic          in_scan;

   assign req_tready = (state_ff == rrss_pkg::S_IDLE) && !rsp_vld_ff;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign scan_idx  = scan_ff[SW-1:0];
   assign scan_done = (scan_ff >= loaded_ff);
   assign in_scan   = (state_ff == rrss_pkg::S_SCAN1) || (state_ff == rrss_pkg::S_SCAN2)
                      || (state_ff == rrss_pkg::S_SCAN3);
   // shared compare: (arrival, id) less than current best
   assign better = !adm_ff[scan_idx] && (!best_vld_ff
                   || arr_ff[scan_idx] < arr_ff[best_ff]
                   || (arr_ff[scan_idx] == arr_ff[best_ff]
                       && ids_ff[scan_idx] < ids_ff[best_ff]));

   logic best_due;
   assign best_due = best_vld_ff && ({8'd0, arr_ff[best_ff]} <= time_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrss_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tuser == rrss_pkg::FUNC_LOAD || req_tuser == rrss_pkg::FUNC_CLEAR) begin
                  state_in = rrss_pkg::S_OUT;
               end else begin
                  state_in = rrss_pkg::S_SCAN1;
               end
            end
         end
         rrss_pkg::S_SCAN1: if (scan_done) state_in = rrss_pkg::S_ADMIT1;
         rrss_pkg::S_ADMIT1: begin
            if (best_due) state_in = rrss_pkg::S_SCAN1;
            else if (nq_cnt_ff == '0 && pq_cnt_ff == '0) state_in = rrss_pkg::S_JUMP;
            else state_in = rrss_pkg::S_POP;
         end
         rrss_pkg::S_JUMP: state_in = best_vld_ff ? rrss_pkg::S_SCAN2 : rrss_pkg::S_OUT;
         rrss_pkg::S_SCAN2: if (scan_done) state_in = rrss_pkg::S_ADMIT2;
         rrss_pkg::S_ADMIT2: state_in = best_due ? rrss_pkg::S_SCAN2 : rrss_pkg::S_POP;
         rrss_pkg::S_POP: state_in = rrss_pkg::S_RUN;
         rrss_pkg::S_RUN: state_in = rrss_pkg::S_SCAN3;
         rrss_pkg::S_SCAN3: if (scan_done) state_in = rrss_pkg::S_ADMIT3;
         rrss_pkg::S_ADMIT3: state_in = best_due ? rrss_pkg::S_SCAN3 : rrss_pkg::S_PUSH;
         rrss_pkg::S_PUSH: state_in = rrss_pkg::S_OUT;
         rrss_pkg::S_OUT: state_in = rrss_pkg::S_IDLE;
         default: state_in = rrss_pkg::S_IDLE;
      endcase
   end

   logic [15:0] dur_now;
   assign dur_now = (rem_ff[cur_ff] < quantum_ff) ? rem_ff[cur_ff] : quantum_ff;

   logic [24:0] time_sum;
   assign time_sum = {1'b0, time_ff} + {9'd0, dur_now};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rrss_pkg::S_IDLE;
         quantum_ff <= rrss_pkg::QuantumReset;
         adm_ff     <= '0;
         started_ff <= '0;
         loaded_ff  <= '0;
         nq_head_ff <= '0;
         pq_head_ff <= '0;
         nq_cnt_ff  <= '0;
         pq_cnt_ff  <= '0;
         time_ff    <= '0;
         rsp_vld_ff <= 1'b0;
         scan_ff    <= '0;
         best_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) quantum_ff <= csr_wr_data;
         if (rsp_vld_ff && rsp_tready) rsp_vld_ff <= 1'b0;
         if (in_scan) begin
            if (!scan_done) begin
               if (better) begin
                  best_ff     <= scan_idx;
                  best_vld_ff <= 1'b1;
               end
               scan_ff <= scan_ff + 1'b1;
            end
         end
         case (state_ff)
            rrss_pkg::S_IDLE: begin
               scan_ff     <= '0;
               best_vld_ff <= 1'b0;
               if (req_tvalid && req_tready) begin
                  rsp_data_ff <= '0;
                  case (req_tuser)
                     rrss_pkg::FUNC_LOAD: begin
                        if (loaded_ff >= CW'(rrss_pkg::MaxTasks)) begin
                           rsp_user_ff <= rrss_pkg::ST_FULL;
                        end else begin
                           ids_ff[loaded_ff[SW-1:0]] <= req_tdata[7:0];
                           arr_ff[loaded_ff[SW-1:0]] <= req_tdata[23:8];
                           rem_ff[loaded_ff[SW-1:0]] <= req_tdata[39:24];
                           adm_ff[loaded_ff[SW-1:0]] <= 1'b0;
                           started_ff[loaded_ff[SW-1:0]] <= 1'b0;
                           loaded_ff <= loaded_ff + 1'b1;
                           rsp_user_ff <= rrss_pkg::ST_LOADED;
                        end
                     end
                     rrss_pkg::FUNC_CLEAR: begin
                        adm_ff <= '0;
                        started_ff <= '0;
                        loaded_ff <= '0;
                        nq_head_ff <= '0;
                        pq_head_ff <= '0;
                        nq_cnt_ff <= '0;
                        pq_cnt_ff <= '0;
                        time_ff <= '0;
                        rsp_user_ff <= rrss_pkg::ST_DONE;
                     end
                     default: rsp_user_ff <= rrss_pkg::ST_SLICE;
                  endcase
               end
            end
            rrss_pkg::S_ADMIT1, rrss_pkg::S_ADMIT2, rrss_pkg::S_ADMIT3: begin
               scan_ff     <= '0;
               best_vld_ff <= best_vld_ff && (state_in == rrss_pkg::S_JUMP);
               if (best_due) begin
                  adm_ff[best_ff] <= 1'b1;
                  if (nq_cnt_ff < CW'(rrss_pkg::MaxTasks)) begin
                     nq_ff[SW'(nq_head_ff + nq_cnt_ff[SW-1:0])] <= best_ff;
                     nq_cnt_ff <= nq_cnt_ff + 1'b1;
                  end
               end
            end
            rrss_pkg::S_JUMP: begin
               scan_ff     <= '0;
               best_vld_ff <= 1'b0;
               if (best_vld_ff) time_ff <= {8'd0, arr_ff[best_ff]};
               else rsp_user_ff <= rrss_pkg::ST_DONE;
            end
            rrss_pkg::S_POP: begin
               if (nq_cnt_ff != '0) begin
                  cur_ff <= nq_ff[nq_head_ff];
                  nq_head_ff <= nq_head_ff + 1'b1;
                  nq_cnt_ff <= nq_cnt_ff - 1'b1;
               end else begin
                  cur_ff <= pq_ff[pq_head_ff];
                  pq_head_ff <= pq_head_ff + 1'b1;
                  pq_cnt_ff <= pq_cnt_ff - 1'b1;
               end
            end
            rrss_pkg::S_RUN: begin
               rsp_data_ff[23:0]  <= time_ff;
               rsp_data_ff[31:24] <= ids_ff[cur_ff];
               rsp_data_ff[47:32] <= dur_now;
               rsp_data_ff[48]    <= (rem_ff[cur_ff] <= quantum_ff);
               rsp_data_ff[49]    <= !started_ff[cur_ff];
               started_ff[cur_ff] <= 1'b1;
               rem_ff[cur_ff]     <= rem_ff[cur_ff] - dur_now;
               time_ff <= time_sum[24] ? rrss_pkg::TimeMax : time_sum[23:0];
               scan_ff     <= '0;
               best_vld_ff <= 1'b0;
            end
            rrss_pkg::S_PUSH: begin
               if (rem_ff[cur_ff] != '0 && pq_cnt_ff < CW'(rrss_pkg::MaxTasks)) begin
                  pq_ff[SW'(pq_head_ff + pq_cnt_ff[SW-1:0])] <= cur_ff;
                  pq_cnt_ff <= pq_cnt_ff + 1'b1;
               end
            end
            rrss_pkg::S_OUT: rsp_vld_ff <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/rrss_checker.sv =====
// Port-level checks for the round-robin slice scheduler.
// Depends on rrss_pkg; bound to round_robin_slice_scheduler_top.
module rrss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   a_no_take_while_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken with result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == rrss_pkg::FUNC_CLEAR |=> ##1
      rsp_tvalid && rsp_tuser == rrss_pkg::ST_DONE) else $error("clear not answered");
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rrss_pkg::ST_SLICE |-> rsp_tdata == '0)
      else $error("nonzero fields");
endmodule

bind round_robin_slice_scheduler_top rrss_checker u_rrss_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

// ===== tb/round_robin_slice_scheduler_top_test.sv =====
// Self-checking test of the round-robin slice scheduler: directed and random load/step/clear
// beats checked against a slice predictor under varied quanta and bus idling.
// Depends on rrss_pkg and round_robin_slice_scheduler_top.
module round_robin_slice_scheduler_top_test;

   typedef struct {
      rrss_pkg::status_type status;
      logic [55:0] fields;
   } slice_result_type;

   class slice_scoreboard_type;
      logic [7:0] ids[rrss_pkg::MaxTasks];
      logic [15:0] arrivals[rrss_pkg::MaxTasks];
      logic [15:0] remaining[rrss_pkg::MaxTasks];
      bit admitted[rrss_pkg::MaxTasks];
      bit started[rrss_pkg::MaxTasks];
      int loaded;
      int fresh_q[$];
      int preempt_q[$];
      logic [23:0] now;
      logic [15:0] quantum;
      slice_result_type pending[$];
      rrss_pkg::status_type last_status;
      int errors;

      function void clear_table();
         loaded = 0;
         fresh_q.delete();
         preempt_q.delete();
         now = '0;
         foreach (admitted[i]) begin
            admitted[i] = 0;
            started[i] = 0;
         end
      endfunction

      function int earliest_waiting();
         int best;
         best = -1;
         for (int i = 0; i < loaded; i++) begin
            if (admitted[i]) continue;
            if (best < 0 || arrivals[i] < arrivals[best] ||
                (arrivals[i] == arrivals[best] && ids[i] < ids[best]))
               best = i;
         end
         return best;
      endfunction

      function void admit_ready();
         int k;
         forever begin
            k = earliest_waiting();
            if (k < 0 || arrivals[k] > now) break;
            admitted[k] = 1;
            fresh_q = {fresh_q, k};
         end
      endfunction

      function void note_item(rrss_pkg::func_type func, logic [7:0] id, logic [15:0] arr,
                              logic [15:0] burst);
         slice_result_type r;
         int k;
         logic [15:0] dur;
         int unsigned t;
         bit fin, first;
         r.fields = '0;
         if (func == rrss_pkg::FUNC_LOAD) begin
            if (loaded >= rrss_pkg::MaxTasks) r.status = rrss_pkg::ST_FULL;
            else begin
               ids[loaded] = id;
               arrivals[loaded] = arr;
               remaining[loaded] = burst;
               admitted[loaded] = 0;
               started[loaded] = 0;
               loaded++;
               r.status = rrss_pkg::ST_LOADED;
            end
         end else if (func == rrss_pkg::FUNC_CLEAR) begin
            clear_table();
            r.status = rrss_pkg::ST_DONE;
         end else begin
            admit_ready();
            k = 0;
            if (fresh_q.size() == 0 && preempt_q.size() == 0) begin
               k = earliest_waiting();
               if (k >= 0) begin
                  now = {8'd0, arrivals[k]};
                  admit_ready();
               end
            end
            if (k < 0) r.status = rrss_pkg::ST_DONE;
            else begin
               k = fresh_q.size() != 0 ? fresh_q.pop_front() : preempt_q.pop_front();
               dur = remaining[k] < quantum ? remaining[k] : quantum;
               first = !started[k];
               started[k] = 1;
               r.fields[23:0] = now;
               r.fields[31:24] = ids[k];
               r.fields[47:32] = dur;
               t = now + dur;
               now = t > rrss_pkg::TimeMax ? rrss_pkg::TimeMax : t[23:0];
               remaining[k] -= dur;
               fin = remaining[k] == 0;
               r.fields[48] = fin;
               r.fields[49] = first;
               admit_ready();
               if (!fin) preempt_q = {preempt_q, k};
               r.status = rrss_pkg::ST_SLICE;
            end
         end
         last_status = r.status;
         pending = {pending, r};
      endfunction

      function void check_slice(logic [1:0] status, logic [55:0] fields);
         slice_result_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected beat: status %0d data %h", $realtime, status, fields);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (status !== e.status) begin
            $display("%0t status: expected %0d actual %0d", $realtime, e.status, status);
            errors++;
         end
         if (fields[23:0] !== e.fields[23:0]) begin
            $display("%0t slice_start: expected %0d actual %0d", $realtime,
                     e.fields[23:0], fields[23:0]);
            errors++;
         end
         if (fields[31:24] !== e.fields[31:24]) begin
            $display("%0t slice_task: expected %0d actual %0d", $realtime,
                     e.fields[31:24], fields[31:24]);
            errors++;
         end
         if (fields[47:32] !== e.fields[47:32]) begin
            $display("%0t slice_length: expected %0d actual %0d", $realtime,
                     e.fields[47:32], fields[47:32]);
            errors++;
         end
         if (fields[48] !== e.fields[48]) begin
            $display("%0t task_finished: expected %0d actual %0d", $realtime,
                     e.fields[48], fields[48]);
            errors++;
         end
         if (fields[49] !== e.fields[49]) begin
            $display("%0t first_run: expected %0d actual %0d", $realtime,
                     e.fields[49], fields[49]);
            errors++;
         end
      endfunction
   endclass

   localparam int StallLimit = 5000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_wr_en = 0;
   logic [15:0] csr_wr_data = '0;

   slice_scoreboard_type sched = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int sent = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   round_robin_slice_scheduler_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sched.check_slice(rsp_tuser, rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
      rsp_tready <= recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct;
   end

   task automatic send(rrss_pkg::func_type func, logic [7:0] id = 0, logic [15:0] arr = 0,
                       logic [15:0] burst = 0);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= func;
      req_tdata <= {burst, arr, id};
      do @(posedge clock); while (!req_tready);
      sched.note_item(func, id, arr, burst);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sched.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_quantum(logic [15:0] q);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= q;
      @(posedge clock);
      csr_wr_en <= 0;
      sched.quantum = q;
   endtask

   task automatic run_to_done(int cap);
      int steps;
      steps = 0;
      do begin
         send(rrss_pkg::FUNC_STEP);
         steps++;
      end while (sched.last_status != rrss_pkg::ST_DONE && steps < cap);
   endtask

   task automatic random_batch();
      int n;
      logic [15:0] arr, burst;
      send(rrss_pkg::FUNC_CLEAR);
      n = $urandom_range(1, rrss_pkg::MaxTasks + 2);
      for (int i = 0; i < n; i++) begin
         arr = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(40));
         burst = $urandom_range(19) == 0 ? 16'($urandom) : 16'($urandom_range(12));
         send(rrss_pkg::FUNC_LOAD, 8'($urandom), arr, burst);
      end
      for (int s = 0; s < 50 && sched.last_status != rrss_pkg::ST_DONE; s++) begin
         case ($urandom_range(19))
            0: send(rrss_pkg::FUNC_LOAD, 8'($urandom), 16'($urandom_range(60)),
                    16'($urandom_range(10)));
            1: send(rrss_pkg::FUNC_SPARE, 8'($urandom), 16'($urandom), 16'($urandom));
            default: send(rrss_pkg::FUNC_STEP);
         endcase
      end
   endtask

   initial begin
      int idle_set[4] = '{0, 60, 0, 24};
      int stall_set[4] = '{0, 0, 60, 24};
      logic [15:0] quanta[4] = '{16'd4, 16'd1, 16'd65535, 16'd7};
      sched.clear_table();
      sched.quantum = rrss_pkg::QuantumReset;
      sched.errors = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(rrss_pkg::FUNC_LOAD, 8'd255, 16'd0, 16'd0);
      send(rrss_pkg::FUNC_LOAD, 8'd0, 16'd0, 16'd9);
      send(rrss_pkg::FUNC_LOAD, 8'd7, 16'd3, 16'd5);
      send(rrss_pkg::FUNC_LOAD, 8'd3, 16'd3, 16'd2);
      send(rrss_pkg::FUNC_LOAD, 8'd1, 16'd65535, 16'd1);
      send(rrss_pkg::FUNC_STEP);
      send(rrss_pkg::FUNC_SPARE, 8'hff, 16'hffff, 16'hffff);
      send(rrss_pkg::FUNC_LOAD, 8'd9, 16'd0, 16'd3);
      run_to_done(20);
      send(rrss_pkg::FUNC_STEP);
      send(rrss_pkg::FUNC_CLEAR);
      for (int i = 0; i <= rrss_pkg::MaxTasks; i++)
         send(rrss_pkg::FUNC_LOAD, 8'(i), 16'd2, 16'd1);
      send(rrss_pkg::FUNC_STEP);

      set_quantum(16'd65535);
      send(rrss_pkg::FUNC_CLEAR);
      send(rrss_pkg::FUNC_LOAD, 8'd42, 16'hffff, 16'hffff);
      run_to_done(4);
      set_quantum(16'd0);
      send(rrss_pkg::FUNC_CLEAR);
      send(rrss_pkg::FUNC_LOAD, 8'd5, 16'd1, 16'd3);
      send(rrss_pkg::FUNC_LOAD, 8'd6, 16'd1, 16'd0);
      run_to_done(4);

      foreach (quanta[p]) begin
         set_quantum(quanta[p]);
         send_idle_pct = idle_set[p];
         recv_stall_pct = stall_set[p];
         while (sent < 60 + 240 * (p + 1)) random_batch();
      end

      drain();
      if (sched.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
